FILE: src/tlc_pkg.sv
`default_nettype none

package tlc_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam int COST_BITS      = 16;
   localparam int COUNT_BITS     = 32;
   localparam int TOTAL_BITS     = 48;
   localparam int LEVEL_BITS     = 2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [COST_BITS-1:0]      cost_type;
   typedef logic [LEVEL_BITS-1:0]     level_type;

   localparam csr_index_type CSR_COST_LEVEL_ONE   = CSR_INDEX_BITS'(0);
   localparam csr_index_type CSR_COST_LEVEL_TWO   = CSR_INDEX_BITS'(1);
   localparam csr_index_type CSR_COST_LEVEL_THREE = CSR_INDEX_BITS'(2);
   localparam csr_index_type CSR_COST_OF_MISS     = CSR_INDEX_BITS'(3);

   localparam cost_type COST_LEVEL_ONE_RESET   = 16'd10;
   localparam cost_type COST_LEVEL_TWO_RESET   = 16'd20;
   localparam cost_type COST_LEVEL_THREE_RESET = 16'd30;
   localparam cost_type COST_OF_MISS_RESET     = 16'd1000;

   localparam level_type LEVEL_HIT_ONE   = 2'd0;
   localparam level_type LEVEL_HIT_TWO   = 2'd1;
   localparam level_type LEVEL_HIT_THREE = 2'd2;
   localparam level_type LEVEL_MISS      = 2'd3;

   typedef struct packed {
      logic load_addr;
      logic compare;
      logic update;
   } tlc_cmd_type;

endpackage

`default_nettype wire

FILE: src/tlc_tag_store.sv
`default_nettype none

module tlc_tag_store #(
   parameter int ENTRIES      = 16,
   parameter int ADDRESS_BITS = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    compare_en,
   input  wire logic                    fill_en,
   input  wire logic [ADDRESS_BITS-1:0] addr,
   output logic                         hit
);

   localparam int PTR_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [ADDRESS_BITS-1:0] tag_ff [ENTRIES];
   logic [ENTRIES-1:0]      valid_ff;
   logic [ENTRIES-1:0]      match_ff;
   logic [ENTRIES-1:0]      match_in;
   logic [PTR_BITS-1:0]     ptr_ff;
   logic [PTR_BITS-1:0]     ptr_in;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (tag_ff[i] == addr);
      end
   end

   assign ptr_in = (ptr_ff == PTR_BITS'(ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
   assign hit    = |match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else if (fill_en) begin
         valid_ff[ptr_ff] <= 1'b1;
         ptr_ff           <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_en) begin
         tag_ff[ptr_ff] <= addr;
      end
      if (compare_en) begin
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/tlc_datapath.sv
`default_nettype none

module tlc_datapath
   import tlc_pkg::*;
#(
   parameter int LEVEL_ONE_ENTRIES   = 16,
   parameter int LEVEL_TWO_ENTRIES   = 32,
   parameter int LEVEL_THREE_ENTRIES = 64,
   parameter int ADDRESS_BITS        = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tlc_cmd_type               cmd,
   input  wire logic [ADDRESS_BITS-1:0]   req_access_address,
   input  wire logic                      csr_write,
   input  wire csr_index_type             csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic [LEVEL_BITS-1:0]          rsp_hit_level,
   output logic [COUNT_BITS-1:0]          rsp_hits_so_far,
   output logic [COUNT_BITS-1:0]          rsp_misses_so_far,
   output logic [TOTAL_BITS-1:0]          rsp_cost_so_far
);

   logic [ADDRESS_BITS-1:0] addr_ff;
   level_type               level_ff;
   level_type               level_in;
   cost_type                cost_one_ff;
   cost_type                cost_two_ff;
   cost_type                cost_three_ff;
   cost_type                cost_miss_ff;
   cost_type                cost_add;
   logic [COUNT_BITS-1:0]   hit_total_ff;
   logic [COUNT_BITS-1:0]   hit_total_in;
   logic [COUNT_BITS-1:0]   miss_total_ff;
   logic [COUNT_BITS-1:0]   miss_total_in;
   logic [TOTAL_BITS-1:0]   cost_total_ff;
   logic [TOTAL_BITS-1:0]   cost_total_in;
   logic [TOTAL_BITS:0]     cost_sum;
   logic                    hit_one;
   logic                    hit_two;
   logic                    hit_three;
   logic                    fill_one;
   logic                    fill_two;
   logic                    fill_three;
   logic                    miss;

   assign fill_one   = cmd.update && !hit_one;
   assign fill_two   = cmd.update && !hit_one && !hit_two;
   assign miss       = !hit_one && !hit_two && !hit_three;
   assign fill_three = cmd.update && miss;

   tlc_tag_store #(
      .ENTRIES      (LEVEL_ONE_ENTRIES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_level_one (
      .clock      (clock),
      .reset      (reset),
      .compare_en (cmd.compare),
      .fill_en    (fill_one),
      .addr       (addr_ff),
      .hit        (hit_one)
   );

   tlc_tag_store #(
      .ENTRIES      (LEVEL_TWO_ENTRIES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_level_two (
      .clock      (clock),
      .reset      (reset),
      .compare_en (cmd.compare),
      .fill_en    (fill_two),
      .addr       (addr_ff),
      .hit        (hit_two)
   );

   tlc_tag_store #(
      .ENTRIES      (LEVEL_THREE_ENTRIES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_level_three (
      .clock      (clock),
      .reset      (reset),
      .compare_en (cmd.compare),
      .fill_en    (fill_three),
      .addr       (addr_ff),
      .hit        (hit_three)
   );

   always_comb begin
      if (hit_one) begin
         level_in = LEVEL_HIT_ONE;
         cost_add = cost_one_ff;
      end else if (hit_two) begin
         level_in = LEVEL_HIT_TWO;
         cost_add = cost_two_ff;
      end else if (hit_three) begin
         level_in = LEVEL_HIT_THREE;
         cost_add = cost_three_ff;
      end else begin
         level_in = LEVEL_MISS;
         cost_add = cost_miss_ff;
      end
   end

   always_comb begin
      hit_total_in  = hit_total_ff;
      miss_total_in = miss_total_ff;
      if (miss) begin
         if (miss_total_ff != '1) begin
            miss_total_in = miss_total_ff + 1'b1;
         end
      end else if (hit_total_ff != '1) begin
         hit_total_in = hit_total_ff + 1'b1;
      end
      cost_sum      = {1'b0, cost_total_ff} + {{(TOTAL_BITS + 1 - COST_BITS){1'b0}}, cost_add};
      cost_total_in = cost_sum[TOTAL_BITS] ? '1 : cost_sum[TOTAL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
         cost_total_ff <= '0;
         cost_one_ff   <= COST_LEVEL_ONE_RESET;
         cost_two_ff   <= COST_LEVEL_TWO_RESET;
         cost_three_ff <= COST_LEVEL_THREE_RESET;
         cost_miss_ff  <= COST_OF_MISS_RESET;
      end else begin
         if (cmd.update) begin
            hit_total_ff  <= hit_total_in;
            miss_total_ff <= miss_total_in;
            cost_total_ff <= cost_total_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_COST_LEVEL_ONE:   cost_one_ff   <= csr_data[COST_BITS-1:0];
               CSR_COST_LEVEL_TWO:   cost_two_ff   <= csr_data[COST_BITS-1:0];
               CSR_COST_LEVEL_THREE: cost_three_ff <= csr_data[COST_BITS-1:0];
               CSR_COST_OF_MISS:     cost_miss_ff  <= csr_data[COST_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_addr) begin
         addr_ff <= req_access_address;
      end
      if (cmd.update) begin
         level_ff <= level_in;
      end
   end

   assign rsp_hit_level     = level_ff;
   assign rsp_hits_so_far   = hit_total_ff;
   assign rsp_misses_so_far = miss_total_ff;
   assign rsp_cost_so_far   = cost_total_ff;

endmodule

`default_nettype wire

FILE: src/tlc_ctrl.sv
`default_nettype none

module tlc_ctrl
   import tlc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output tlc_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign cmd.load_addr = req_valid && req_ready;
   assign cmd.compare   = (state_ff == S_LOOKUP);
   assign cmd.update    = (state_ff == S_UPDATE) && out_free;

   // result register must be free or draining when an update lands
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_valid_ff || rsp_ready))
      else $error("update while result register still held");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.compare)
      else $error("accepted transfer not followed by tag compare");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.update))
      else $error("result raised without an update");

endmodule

`default_nettype wire

FILE: src/three_level_cache_lookup_fifo.sv
// a request transfer is followed by the compare state, then the update state, which registers result valid
// one access at a time, in the capture, compare, update sequence; req_ready stays low until it ends
// a new request is taken while the previous result waits; update stalls if it is unread
// reset: synchronous, active high; tag stores invalid, fill pointers and totals zero,
// cost registers back to 10, 20, 30 and 1000
`default_nettype none

module three_level_cache_lookup_fifo
   import tlc_pkg::*;
#(
   parameter int LEVEL_ONE_ENTRIES   = 16,
   parameter int LEVEL_TWO_ENTRIES   = 32,
   parameter int LEVEL_THREE_ENTRIES = 64,
   parameter int ADDRESS_BITS        = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ADDRESS_BITS-1:0]   req_access_address,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [LEVEL_BITS-1:0]          rsp_hit_level,
   output logic [COUNT_BITS-1:0]          rsp_hits_so_far,
   output logic [COUNT_BITS-1:0]          rsp_misses_so_far,
   output logic [TOTAL_BITS-1:0]          rsp_cost_so_far,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire csr_index_type             csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   tlc_cmd_type cmd;

   assign csr_ready = 1'b1;

   tlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   tlc_datapath #(
      .LEVEL_ONE_ENTRIES   (LEVEL_ONE_ENTRIES),
      .LEVEL_TWO_ENTRIES   (LEVEL_TWO_ENTRIES),
      .LEVEL_THREE_ENTRIES (LEVEL_THREE_ENTRIES),
      .ADDRESS_BITS        (ADDRESS_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_access_address (req_access_address),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_hit_level      (rsp_hit_level),
      .rsp_hits_so_far    (rsp_hits_so_far),
      .rsp_misses_so_far  (rsp_misses_so_far),
      .rsp_cost_so_far    (rsp_cost_so_far)
   );

endmodule

`default_nettype wire
